FILE: hdl/packet_deframer_xor_checksum_assert.svh
// Assertion macros for the packet deframer checker.
// No dependencies; included by the checker module.
`ifndef PACKET_DEFRAMER_XOR_CHECKSUM_ASSERT_SVH
`define PACKET_DEFRAMER_XOR_CHECKSUM_ASSERT_SVH

// Same-cycle implication, disabled while rstn is low.
`define PDXC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while rstn is low.
`define PDXC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pdxc_pkg.sv
// Shared types and constants for the packet deframer.
// No dependencies; used by the parser, result queue and top level.
package pdxc_pkg;

    localparam logic [3:0] SEQ_CHK_BYTES = 4'd8;   // header bytes holding sequence and checksum
    localparam logic [3:0] HDR_LAST      = 4'd11;  // index of the final header byte
    localparam logic [7:0] PAD_BYTE      = 8'hAB;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = 2;
    localparam int unsigned FIFO_CNT_W = 3;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_BAD      = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_TRUNC    = 2'd3
    } t_status;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [31:0] seq;
        logic [15:0] len;
        t_status     status;
        logic        last;
    } t_result;

    // up to two results produced by one accepted byte
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

FILE: hdl/pdxc_parser.sv
// Header/payload parser with running XOR-32 checksum and config register.
// Depends on pdxc_pkg; produces up to two results per accepted byte.
module pdxc_parser #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [15:0]         i_cfg_wr_data,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    input  logic                i_eos,
    output pdxc_pkg::t_push     o_push
);

    localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);

    typedef enum logic {PH_HEADER, PH_PAYLOAD} t_phase;

    t_phase                  r_phase, n_phase;
    logic [3:0]              r_hcnt, n_hcnt;
    logic [63:0]             r_hdr, n_hdr;
    logic [31:0]             r_len, n_len;
    logic [LENGTH_BITS-1:0]  r_cnt, n_cnt;
    logic [31:0]             r_acc, n_acc;
    logic [15:0]             r_max_len;

    logic [31:0]             seq, chk, len_in, v_len, byte_word, pad_word, acc_x, acc_fin;
    logic [LENGTH_BITS-1:0]  cnt_inc;
    logic                    prim_v, sec_v, trunc_v, pkt_done, hdr_done;
    pdxc_pkg::t_result       prim, sec, trunc;

    function automatic pdxc_pkg::t_result mk(
        logic kind, logic [7:0] pb, logic vis, logic [31:0] sq, logic [31:0] ln,
        pdxc_pkg::t_status st
    );
        pdxc_pkg::t_result r;
        r.kind         = kind;
        r.payload_byte = pb;
        r.seq          = vis ? sq : 32'd0;
        r.len          = !vis ? 16'd0 : ((|ln[31:16]) ? 16'hFFFF : ln[15:0]);
        r.status       = st;
        r.last         = 1'b0;
        return r;
    endfunction

    assign seq     = r_hdr[63:32];
    assign chk     = r_hdr[31:0];
    assign len_in  = {r_len[23:0], i_byte};
    assign cnt_inc = r_cnt + 1'b1;
    assign v_len   = (r_phase == PH_HEADER) ? len_in : r_len;

    // place the byte into its big-endian lane; pad the lanes after it
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: begin
                byte_word = {i_byte, 24'd0};
                pad_word  = {8'd0, {3{pdxc_pkg::PAD_BYTE}}};
            end
            2'd1: begin
                byte_word = {8'd0, i_byte, 16'd0};
                pad_word  = {16'd0, {2{pdxc_pkg::PAD_BYTE}}};
            end
            2'd2: begin
                byte_word = {16'd0, i_byte, 8'd0};
                pad_word  = {24'd0, pdxc_pkg::PAD_BYTE};
            end
            default: begin
                byte_word = {24'd0, i_byte};
                pad_word  = 32'd0;
            end
        endcase
    end

    assign acc_x   = r_acc ^ byte_word;
    assign acc_fin = acc_x ^ pad_word;

    always_comb begin
        n_phase  = r_phase;
        n_hcnt   = r_hcnt;
        n_hdr    = r_hdr;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        prim_v   = 1'b0;
        sec_v    = 1'b0;
        pkt_done = 1'b0;
        hdr_done = 1'b0;
        prim     = mk(pdxc_pkg::KIND_DATA, i_byte, 1'b1, seq, r_len, pdxc_pkg::ST_GOOD);
        sec      = mk(pdxc_pkg::KIND_VERDICT, 8'd0, 1'b1, seq, r_len,
                      (acc_fin == chk) ? pdxc_pkg::ST_GOOD : pdxc_pkg::ST_BAD);
        if (i_take) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_hcnt < pdxc_pkg::SEQ_CHK_BYTES) begin
                        n_hdr = {r_hdr[55:0], i_byte};
                    end else begin
                        n_len = len_in;
                    end
                    n_hcnt = r_hcnt + 4'd1;
                    if (r_hcnt == pdxc_pkg::HDR_LAST) begin
                        hdr_done = 1'b1;
                        n_hcnt   = 4'd0;
                        n_cnt    = '0;
                        n_acc    = seq;
                        if (len_in > {16'd0, r_max_len} || len_in > LEN_MASK) begin
                            prim_v   = 1'b1;
                            pkt_done = 1'b1;
                            prim     = mk(pdxc_pkg::KIND_VERDICT, 8'd0, 1'b1, seq, len_in,
                                          pdxc_pkg::ST_TOO_LONG);
                        end else if (len_in == 32'd0) begin
                            prim_v   = 1'b1;
                            pkt_done = 1'b1;
                            prim     = mk(pdxc_pkg::KIND_VERDICT, 8'd0, 1'b1, seq, len_in,
                                          (seq == chk) ? pdxc_pkg::ST_GOOD : pdxc_pkg::ST_BAD);
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    hdr_done = 1'b1;
                    prim_v   = 1'b1;
                    n_acc    = acc_x;
                    n_cnt    = cnt_inc;
                    if (cnt_inc == r_len[LENGTH_BITS-1:0]) begin
                        sec_v    = 1'b1;
                        pkt_done = 1'b1;
                        n_phase  = PH_HEADER;
                        n_cnt    = '0;
                    end
                end
                default: ;
            endcase
            if (i_eos) begin
                n_phase = PH_HEADER;
                n_hcnt  = 4'd0;
                n_cnt   = '0;
            end
        end
    end

    assign trunc_v = i_take && i_eos && !pkt_done;
    assign trunc   = mk(pdxc_pkg::KIND_VERDICT, 8'd0, hdr_done, seq, v_len,
                        pdxc_pkg::ST_TRUNC);

    always_comb begin
        o_push.cnt = {1'b0, prim_v} + {1'b0, sec_v} + {1'b0, trunc_v};
        o_push.r0  = prim_v ? prim : trunc;
        o_push.r1  = sec_v ? sec : trunc;
        o_push.r0.last = (o_push.cnt == 2'd1);
        o_push.r1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hcnt    <= 4'd0;
            r_cnt     <= '0;
            r_max_len <= 16'hFFFF;
        end else begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_cnt   <= n_cnt;
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
        r_len <= n_len;
        r_acc <= n_acc;
    end

endmodule

FILE: hdl/pdxc_res_fifo.sv
// Four-entry result queue taking up to two results per cycle.
// Depends on pdxc_pkg; its head drives the output stream.
module pdxc_res_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pdxc_pkg::t_push     i_push,
    input  logic                i_pop_ready,
    output logic                o_valid,
    output pdxc_pkg::t_result   o_head,
    output logic                o_space
);

    localparam int unsigned DEPTH = pdxc_pkg::FIFO_DEPTH;
    localparam int unsigned PW    = pdxc_pkg::FIFO_PTR_W;
    localparam int unsigned CW    = pdxc_pkg::FIFO_CNT_W;

    pdxc_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]     r_wp, r_rp, wp1;
    logic [CW-1:0]     r_cnt;
    logic              pop;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    assign pop     = o_valid && i_pop_ready;
    assign wp1     = r_wp + 1'b1;
    // room for a worst-case two-result byte
    assign o_space = (r_cnt <= CW'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PW'(i_push.cnt);
            r_cnt <= r_cnt + CW'(i_push.cnt) - CW'(pop);
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wp1] <= i_push.r1;
        end
    end

endmodule

FILE: hdl/packet_deframer_xor_checksum.sv
// Top level of the length-prefixed packet deframer with XOR-32 checksum check.
// Depends on pdxc_pkg, pdxc_parser and pdxc_res_fifo.
//
// Channel   Dir  Payload                                          Marker
// s_axis    in   tdata[7:0] stream_byte                           tlast = end_of_stream
// m_axis    out  tdata: byte, seq, length, status (see port)      tlast = last, tuser = kind
// cfg       in   wr_data[15:0] max_payload_length                 wr_en
//
// One byte is accepted per clock while the queue has room; its results are queued at
// the accepting edge and are offered on m_axis from the next cycle, behind older results.
// A byte causing two results (payload byte plus verdict) fills the queue by two, so input
// ready drops for a cycle when three results are queued and the output drains one per cycle.
// The queue is four deep; s_axis ready is high while at least two entries are free.
// Synchronous active-low reset: parser at header start, queue empty, max length 65535.
module packet_deframer_xor_checksum #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] stream_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [7:0] payload_byte, [39:8] sequence_number,
                                          // [55:40] payload_length, [57:56] verdict_status
    output logic        o_m_axis_tlast,
    output logic        o_m_axis_tuser    // [0] result_kind
);

    pdxc_pkg::t_push    push;
    pdxc_pkg::t_result  head;
    logic               space;
    logic               take;

    assign take            = i_s_axis_tvalid && space;
    assign o_s_axis_tready = space;

    pdxc_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_take        (take),
        .i_byte        (i_s_axis_tdata),
        .i_eos         (i_s_axis_tlast),
        .o_push        (push)
    );

    pdxc_res_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop_ready (i_m_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .o_head      (head),
        .o_space     (space)
    );

    assign o_m_axis_tdata = {6'd0, head.status, head.len, head.seq, head.payload_byte};
    assign o_m_axis_tlast = head.last;
    assign o_m_axis_tuser = head.kind;

endmodule

FILE: hdl/pdxc_checker.sv
// Port-level checker for the packet deframer, bound to the top level.
// Depends on packet_deframer_xor_checksum_assert.svh.
`include "packet_deframer_xor_checksum_assert.svh"

module pdxc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic        o_m_axis_tuser
);

    // a stalled result holds
    `PDXC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser),
        "stalled result changed")

    // reset leaves the queue empty and the input open
    `PDXC_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n,
        !o_m_axis_tvalid && o_s_axis_tready, "queue not empty after reset")

    // end of stream always yields at least one result
    `PDXC_ASSERT_NEXT(a_eos_result, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast, o_m_axis_tvalid,
        "no result after end of stream")

    // input backpressure only comes from queued results
    `PDXC_ASSERT_IMPL(a_ready_low, i_clk, i_rst_n, !o_s_axis_tready, o_m_axis_tvalid,
        "input stalled with empty queue")

endmodule

bind packet_deframer_xor_checksum pdxc_checker u_pdxc_checker (.*);
